// File: rtl/core/pru_pkg.sv
`default_nettype none
package pru_pkg;
  localparam int NtBytes = 2048;
  localparam int OamBytes = 256;
  localparam int PatBytes = 8192;
  localparam int PalEntries = 32;
  localparam int NtAw = $clog2(NtBytes);
  localparam int OamAw = $clog2(OamBytes);
  localparam int PatAw = $clog2(PatBytes);
  localparam int PalAw = $clog2(PalEntries);

  localparam logic [3:0] MODE_READ = 4'd0;
  localparam logic [3:0] MODE_WRITE = 4'd1;
  localparam logic [3:0] MODE_CX = 4'd2;
  localparam logic [3:0] MODE_FY = 4'd3;
  localparam logic [3:0] MODE_COPYX = 4'd4;
  localparam logic [3:0] MODE_COPYY = 4'd5;
  localparam logic [3:0] MODE_VBL = 4'd6;
  localparam logic [3:0] MODE_CLR = 4'd7;
  localparam logic [3:0] MODE_HIT = 4'd8;
  localparam logic [3:0] MODE_OVF = 4'd9;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR = 3'd6;
  localparam logic [2:0] REG_DATA = 3'd7;

  typedef struct packed {
    logic start;   // latch item and issue memory reads
    logic finish;  // exec state: update state, load result
  } pru_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/pru_ram.sv
`default_nettype none
module pru_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/pru_ctrl.sv
`default_nettype none
module pru_ctrl
  import pru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pru_cmd_t      cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;
  logic [1:0] state, state_next;

  // next item may enter while the result waits if the result is taken now
  always_comb begin
    in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
    out_valid = (state == S_OUT);
    cmd.start = in_valid && in_ready;
    cmd.finish = (state == S_EXEC);
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// File: rtl/core/pru_dp.sv
`default_nettype none
module pru_dp
  import pru_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  pru_cmd_t         cmd,
  input  wire logic        mirror_mode,
  input  wire logic [3:0]  mode,
  input  wire logic [2:0]  reg_index,
  input  wire logic [7:0]  write_data,
  output logic      [7:0]  read_data,
  output logic             nmi_request,
  output logic      [14:0] vram_address,
  output logic      [2:0]  fine_x_scroll
);
  logic [14:0] v, t;
  logic [2:0]  fx;
  logic        wt;
  logic [7:0]  rbuf, ctrl, mask;
  logic [2:0]  st;
  logic [7:0]  oamp;
  logic [3:0]  m;
  logic [2:0]  r;
  logic [7:0]  d;
  logic        pal0_written;

  logic [7:0] oam_q, nt_q, pat_q, pal_q;
  logic [13:0] a, ba;
  logic [NtAw-1:0] nt_ra, nt_wa;
  logic [PalAw-1:0] pal_ra, pal_bra, pal_wa;

  function automatic logic [NtAw-1:0] nt_idx(input logic [13:0] ad, input logic mm);
    logic hi;
    hi = mm ? ad[10] : ad[11];
    return NtAw'({hi, ad[9:0]});
  endfunction

  function automatic logic [PalAw-1:0] pal_idx(input logic [13:0] ad);
    logic [4:0] p;
    p = ad[4:0];
    if (p[4] && p[1:0] == 2'b00) p[4] = 1'b0;
    return PalAw'(p);
  endfunction

  // read addresses come from the live v at issue time
  assign a = v[13:0];
  assign ba = (a >= 14'h3F00) ? (a & 14'h2FFF) : a;
  assign nt_ra = nt_idx(ba, mirror_mode);
  assign pal_ra = pal_idx(a);
  assign pal_bra = pal_idx(ba);

  logic dw;
  logic oam_we, nt_we, pat_we, pal_we;
  assign dw = cmd.finish && m == MODE_WRITE && r == REG_DATA;
  assign oam_we = cmd.finish && m == MODE_WRITE && r == REG_OAMDATA;
  assign pat_we = dw && a < 14'h2000;
  assign nt_we = dw && a >= 14'h2000 && a < 14'h3F00;
  assign pal_we = dw && a >= 14'h3F00;
  assign nt_wa = nt_idx(a, mirror_mode);
  assign pal_wa = pal_idx(a);

  // palette: port read address is always the data-port address
  logic pal_sel_buf;
  logic [PalAw-1:0] pal_rd_addr;
  assign pal_rd_addr = pal_ra;

  pru_ram #(.Width(8), .Depth(OamBytes)) u_oam (
    .clk, .we(oam_we), .waddr(OamAw'(oamp)), .wdata(d),
    .raddr(OamAw'(oamp)), .rdata(oam_q));
  pru_ram #(.Width(8), .Depth(NtBytes)) u_nt (
    .clk, .we(nt_we), .waddr(nt_wa), .wdata(d), .raddr(nt_ra), .rdata(nt_q));
  pru_ram #(.Width(8), .Depth(PatBytes)) u_pat (
    .clk, .we(pat_we), .waddr(PatAw'(a)), .wdata(d),
    .raddr(PatAw'(ba)), .rdata(pat_q));
  pru_ram #(.Width(8), .Depth(PalEntries)) u_pal (
    .clk, .we(pal_we), .waddr(pal_wa), .wdata(d),
    .raddr(pal_rd_addr), .rdata(pal_q));

  // buffer refill source class, latched at issue
  logic [1:0] src;
  logic pal_hit0, pal_hit0_q;
  assign pal_hit0 = (pal_ra == '0);
  assign pal_sel_buf = (ba >= 14'h3F00);

  logic [7:0] pal_val, buf_val;
  assign pal_val = (pal_hit0_q && !pal0_written) ? 8'h0F : pal_q;
  always_comb begin
    case (src)
      2'd0: buf_val = pat_q;
      2'd1: buf_val = nt_q;
      default: buf_val = pal_val;
    endcase
  end

  logic [14:0] v_n, t_n;
  logic [2:0] fx_n, st_n;
  logic wt_n;
  logic [7:0] rbuf_n, ctrl_n, mask_n, oamp_n, rd_n;
  logic nmi_n;
  logic [14:0] inc;
  logic [4:0] cy;
  logic rendering;

  always_comb begin
    v_n = v; t_n = t; fx_n = fx; wt_n = wt; rbuf_n = rbuf; ctrl_n = ctrl;
    mask_n = mask; st_n = st; oamp_n = oamp; rd_n = 8'h00; nmi_n = 1'b0;
    inc = ctrl[2] ? 15'd32 : 15'd1;
    rendering = mask[3] || mask[4];
    cy = v[9:5];
    case (m)
      MODE_READ: begin
        case (r)
          REG_STATUS: begin
            rd_n = {st, rbuf[4:0]};
            st_n[2] = 1'b0;
            wt_n = 1'b0;
          end
          REG_OAMDATA: rd_n = oam_q;
          REG_DATA: begin
            rd_n = (a >= 14'h3F00) ? pal_val : rbuf;
            rbuf_n = buf_val;
            v_n = v + inc;
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (r)
          REG_CTRL: begin
            ctrl_n = d;
            t_n = {t[14:12], d[1:0], t[9:0]};
          end
          REG_MASK: mask_n = d;
          REG_OAMADDR: oamp_n = d;
          REG_OAMDATA: oamp_n = oamp + 8'd1;
          REG_SCROLL: begin
            if (!wt) begin
              t_n = {t[14:5], d[7:3]};
              fx_n = d[2:0];
            end else begin
              t_n = {d[2:0], t[11:10], d[7:3], t[4:0]};
            end
            wt_n = !wt;
          end
          REG_ADDR: begin
            if (!wt) t_n = {1'b0, d[5:0], t[7:0]};
            else begin
              t_n = {t[14:8], d};
              v_n = {t[14:8], d};
            end
            wt_n = !wt;
          end
          REG_DATA: v_n = v + inc;
          default: ;
        endcase
      end
      MODE_CX: if (rendering) begin
        if (v[4:0] == 5'd31) v_n = {v[14:11], ~v[10], v[9:5], 5'd0};
        else v_n = v + 15'd1;
      end
      MODE_FY: if (rendering) begin
        if (v[14:12] != 3'd7) v_n = v + 15'h1000;
        else begin
          v_n = {3'd0, v[11:0]};
          if (cy == 5'd29) begin
            v_n[11] = ~v[11];
            v_n[9:5] = 5'd0;
          end else if (cy == 5'd31) v_n[9:5] = 5'd0;
          else v_n[9:5] = cy + 5'd1;
        end
      end
      MODE_COPYX: if (rendering) v_n = (v & 15'h7BE0) | (t & 15'h041F);
      MODE_COPYY: if (rendering) v_n = (v & 15'h041F) | (t & 15'h7BE0);
      MODE_VBL: begin
        st_n[2] = 1'b1;
        nmi_n = ctrl[7];
      end
      MODE_CLR: st_n = 3'd0;
      MODE_HIT: st_n[1] = 1'b1;
      MODE_OVF: st_n[0] = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m <= mode; r <= reg_index; d <= write_data;
      src <= pal_sel_buf ? 2'd2 : (ba >= 14'h2000 ? 2'd1 : 2'd0);
      pal_hit0_q <= pal_sel_buf ? (pal_bra == '0) : pal_hit0;
    end
    if (cmd.finish) begin
      read_data <= rd_n;
      nmi_request <= nmi_n;
      vram_address <= v_n;
      fine_x_scroll <= fx_n;
    end
    if (rst) begin
      v <= '0; t <= '0; fx <= '0; wt <= 1'b0; rbuf <= '0; ctrl <= '0;
      mask <= '0; st <= '0; oamp <= '0; pal0_written <= 1'b0;
    end else if (cmd.finish) begin
      v <= v_n; t <= t_n; fx <= fx_n; wt <= wt_n; rbuf <= rbuf_n;
      ctrl <= ctrl_n; mask <= mask_n; st <= st_n; oamp <= oamp_n;
      if (pal_we && pal_wa == '0) pal0_written <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/ppu_register_and_scroll_unit.sv
`default_nettype none
// channel   | direction | tdata / tuser
// s_axis    | in        | tdata: mode[3:0], reg_index[6:4], write_data[14:7]
// m_axis    | out       | tdata: read_data[7:0], nmi_request[8], vram_address[23:9],
//           |           |        fine_x_scroll[26:24]
// cfg       | in        | cfg_we, cfg_wdata: mirror_mode
// each item first issues the memory read, then updates state in the exec state (the
// ram ports have a registered read); the result then sits in the output register
// and a new item is taken in the cycle it is taken out.
// reset is synchronous; the memories are not cleared, palette entry zero reads
// 0x0F until it is written. a stalled result blocks further input.
module ppu_register_and_scroll_unit
  import pru_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // mode, reg_index, write_data
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // read_data, nmi_request, vram_address, fine_x_scroll
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata      // mirror_mode
);
  pru_cmd_t cmd;
  logic mirror_mode;
  logic [7:0] read_data;
  logic nmi_request;
  logic [14:0] vram_address;
  logic [2:0] fine_x_scroll;

  always_ff @(posedge clk) begin
    if (rst) mirror_mode <= 1'b1;
    else if (cfg_we) mirror_mode <= cfg_wdata;
  end

  pru_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd);

  pru_dp u_dp (
    .clk, .rst, .cmd, .mirror_mode,
    .mode(s_axis_tdata[3:0]), .reg_index(s_axis_tdata[6:4]),
    .write_data(s_axis_tdata[14:7]),
    .read_data, .nmi_request, .vram_address, .fine_x_scroll);

  assign m_axis_tdata = {5'd0, fine_x_scroll, vram_address, nmi_request, read_data};
endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import pru_pkg::*;

  typedef struct packed {
    logic [7:0]  rd;
    logic        nmi;
    logic [14:0] v;
    logic [2:0]  fx;
  } scroll_res_t;

  typedef struct {
    logic [3:0]  mode;
    logic [2:0]  rg;
    logic [7:0]  wd;
    bit          typed;
    scroll_res_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // mode[3:0], reg_index[6:4], write_data[14:7]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // read_data[7:0], nmi_request[8], vram_address[23:9],
                               // fine_x_scroll[26:24]
  logic        cfg_we;
  logic        cfg_wdata;      // mirror_mode

  ppu_register_and_scroll_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // shadow copy of the scroll unit
  logic        sh_mirror;
  logic [14:0] sh_v, sh_t;
  logic [2:0]  sh_fx;
  logic        sh_toggle;
  logic [7:0]  sh_buf, sh_ctrl, sh_mask, sh_oam_ptr;
  logic [2:0]  sh_status;
  logic [7:0]  sh_oam [OamBytes];
  logic [7:0]  sh_nt [NtBytes];
  logic [7:0]  sh_pal [PalEntries];
  logic [7:0]  sh_pat [PatBytes];
  bit          oam_wr [OamBytes];
  bit          nt_wr [NtBytes];
  bit          pal_wr [PalEntries];
  bit          pat_wr [PatBytes];

  scroll_res_t pending_res [$];
  int          src_idle, dst_idle;
  int          errors;
  int          hold_asked, hold_done, hold_left;
  dir_row_t    dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [10:0] nt_slot(input logic [13:0] a);
    logic hi;
    hi = sh_mirror ? a[10] : a[11];
    return {hi, a[9:0]};
  endfunction

  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    logic [4:0] p;
    p = a[4:0];
    if ((p & 5'h13) == 5'h10) p[4] = 1'b0;
    return p;
  endfunction

  function automatic bit loc_written(input logic [13:0] a);
    if (a < 14'h2000) return pat_wr[a[12:0]];
    if (a < 14'h3F00) return nt_wr[nt_slot(a)];
    return pal_wr[pal_slot(a)];
  endfunction

  function automatic logic [7:0] vmem_rd(input logic [13:0] a);
    if (a < 14'h2000) return sh_pat[a[12:0]];
    if (a < 14'h3F00) return sh_nt[nt_slot(a)];
    return sh_pal[pal_slot(a)];
  endfunction

  task automatic vmem_wr(input logic [13:0] a, input logic [7:0] d);
    if (a < 14'h2000) begin
      sh_pat[a[12:0]] = d;
      pat_wr[a[12:0]] = 1;
    end else if (a < 14'h3F00) begin
      sh_nt[nt_slot(a)] = d;
      nt_wr[nt_slot(a)] = 1;
    end else begin
      sh_pal[pal_slot(a)] = d;
      pal_wr[pal_slot(a)] = 1;
    end
  endtask

  // a read must never touch memory that was not written
  function automatic bit read_legal(input logic [2:0] rg);
    logic [13:0] a;
    a = sh_v[13:0];
    if (rg == REG_OAMDATA) return oam_wr[sh_oam_ptr];
    if (rg == REG_DATA) begin
      if (a >= 14'h3F00) return pal_wr[pal_slot(a)] && loc_written(a & 14'h2FFF);
      return loc_written(a);
    end
    return 1;
  endfunction

  task automatic bump_addr();
    sh_v = sh_v + (sh_ctrl[2] ? 15'd32 : 15'd1);
  endtask

  task automatic scroll_step(input logic [3:0] mode, input logic [2:0] rg,
                             input logic [7:0] d, output scroll_res_t r);
    logic        rendering;
    logic [13:0] a;
    logic [4:0]  cy;
    rendering = (sh_mask & 8'h18) != 0;
    r = '0;
    case (mode)
      MODE_READ: begin
        case (rg)
          REG_STATUS: begin
            r.rd = {sh_status, sh_buf[4:0]};
            sh_status[2] = 1'b0;
            sh_toggle = 1'b0;
          end
          REG_OAMDATA: r.rd = sh_oam[sh_oam_ptr];
          REG_DATA: begin
            a = sh_v[13:0];
            if (a >= 14'h3F00) begin
              r.rd = sh_pal[pal_slot(a)];
              sh_buf = vmem_rd(a & 14'h2FFF);
            end else begin
              r.rd = sh_buf;
              sh_buf = vmem_rd(a);
            end
            bump_addr();
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (rg)
          REG_CTRL: begin
            sh_ctrl = d;
            sh_t[11:10] = d[1:0];
          end
          REG_MASK: sh_mask = d;
          REG_OAMADDR: sh_oam_ptr = d;
          REG_OAMDATA: begin
            sh_oam[sh_oam_ptr] = d;
            oam_wr[sh_oam_ptr] = 1;
            sh_oam_ptr = sh_oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!sh_toggle) begin
              sh_t[4:0] = d[7:3];
              sh_fx = d[2:0];
            end else begin
              sh_t[14:12] = d[2:0];
              sh_t[9:5] = d[7:3];
            end
            sh_toggle = ~sh_toggle;
          end
          REG_ADDR: begin
            if (!sh_toggle) begin
              sh_t[14:8] = {1'b0, d[5:0]};
            end else begin
              sh_t[7:0] = d;
              sh_v = sh_t;
            end
            sh_toggle = ~sh_toggle;
          end
          REG_DATA: begin
            vmem_wr(sh_v[13:0], d);
            bump_addr();
          end
          default: ;
        endcase
      end
      MODE_CX: if (rendering) begin
        if (sh_v[4:0] == 5'd31) begin
          sh_v[4:0] = 5'd0;
          sh_v[10] = ~sh_v[10];
        end else begin
          sh_v = sh_v + 15'd1;
        end
      end
      MODE_FY: if (rendering) begin
        if (sh_v[14:12] != 3'd7) begin
          sh_v[14:12] = sh_v[14:12] + 3'd1;
        end else begin
          sh_v[14:12] = 3'd0;
          cy = sh_v[9:5];
          if (cy == 5'd29) begin
            cy = 5'd0;
            sh_v[11] = ~sh_v[11];
          end else if (cy == 5'd31) begin
            cy = 5'd0;
          end else begin
            cy = cy + 5'd1;
          end
          sh_v[9:5] = cy;
        end
      end
      MODE_COPYX: if (rendering) sh_v = (sh_v & 15'h7BE0) | (sh_t & 15'h041F);
      MODE_COPYY: if (rendering) sh_v = (sh_v & 15'h041F) | (sh_t & 15'h7BE0);
      MODE_VBL: begin
        sh_status[2] = 1'b1;
        r.nmi = sh_ctrl[7];
      end
      MODE_CLR: sh_status = 3'd0;
      MODE_HIT: sh_status[1] = 1'b1;
      MODE_OVF: sh_status[0] = 1'b1;
      default: ;
    endcase
    r.v = sh_v;
    r.fx = sh_fx;
  endtask

  // sender: predicts, queues the expectation and hands the item over
  task automatic offer(input logic [3:0] mode, input logic [2:0] rg, input logic [7:0] d,
                       input bit typed = 0, input scroll_res_t typed_res = '0);
    scroll_res_t r;
    if (mode == MODE_READ && !read_legal(rg)) mode = MODE_WRITE;
    scroll_step(mode, rg, d, r);
    pending_res.push_back(typed ? typed_res : r);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, d, rg, mode};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mirror(input logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    sh_mirror = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic point_at(input logic [13:0] a);
    offer(MODE_READ, REG_STATUS, 8'd0);
    offer(MODE_WRITE, REG_ADDR, {2'($urandom_range(3)), a[13:8]});
    offer(MODE_WRITE, REG_ADDR, a[7:0]);
  endtask

  task automatic random_run(input int count);
    int          sent, n, k, pick;
    logic [13:0] a;
    logic [7:0]  p;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (sent > count / 3 && hold_asked == hold_done &&
          (hold_asked == 0 || $urandom_range(150) == 0)) begin
        hold_asked++;
      end
      if (pick < 30) begin
        case ($urandom_range(2))
          0: a = 14'($urandom_range(16'h1FFF));
          1: a = 14'($urandom_range(16'h3EFF, 16'h2000));
          default: a = 14'($urandom_range(16'h3FFF, 16'h3F00));
        endcase
        n = $urandom_range(4, 1);
        offer(MODE_WRITE, REG_CTRL, 8'($urandom_range(255)));
        point_at(a);
        for (k = 0; k < n; k++) offer(MODE_WRITE, REG_DATA, 8'($urandom_range(255)));
        point_at(a);
        for (k = 0; k <= n; k++) offer(MODE_READ, REG_DATA, 8'($urandom_range(255)));
        sent += 2 * n + 8;
      end else if (pick < 45) begin
        p = 8'($urandom_range(255));
        n = $urandom_range(4, 1);
        offer(MODE_WRITE, REG_OAMADDR, p);
        for (k = 0; k < n; k++) offer(MODE_WRITE, REG_OAMDATA, 8'($urandom_range(255)));
        offer(MODE_WRITE, REG_OAMADDR, p + 8'($urandom_range(n - 1)));
        offer(MODE_READ, REG_OAMDATA, 8'($urandom_range(255)));
        sent += n + 3;
      end else if (pick < 70) begin
        offer(MODE_READ, REG_STATUS, 8'd0);
        offer(MODE_WRITE, REG_SCROLL, 8'($urandom_range(255)));
        offer(MODE_WRITE, REG_SCROLL, 8'($urandom_range(255)));
        if ($urandom_range(1)) begin
          offer(MODE_WRITE, REG_ADDR, 8'($urandom_range(255)));
          offer(MODE_WRITE, REG_ADDR, 8'($urandom_range(255)));
        end
        offer(MODE_WRITE, REG_MASK,
              8'($urandom_range(255)) | ($urandom_range(9) != 0 ? 8'h08 : 8'h00));
        n = $urandom_range(12, 4);
        for (k = 0; k < n; k++) offer(4'($urandom_range(MODE_COPYY, MODE_CX)), 3'd0, 8'd0);
        sent += n + 6;
      end else if (pick < 85) begin
        n = $urandom_range(6, 2);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(3))
            0: offer(MODE_WRITE, REG_CTRL, 8'($urandom_range(255)));
            1: offer(MODE_READ, REG_STATUS, 8'($urandom_range(255)));
            default: offer(4'($urandom_range(MODE_OVF, MODE_VBL)), 3'($urandom_range(7)),
                           8'($urandom_range(255)));
          endcase
        end
        sent += n;
      end else begin
        offer(4'($urandom_range(15)), 3'($urandom_range(7)), 8'($urandom_range(255)));
        sent++;
      end
      if (sent > count / 2 && sent < count / 2 + 12) wait_drained();
    end
  endtask

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_done <= 0;
      hold_left <= 0;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    scroll_res_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.rd = m_axis_tdata[7:0];
      got.nmi = m_axis_tdata[8];
      got.v = m_axis_tdata[23:9];
      got.fx = m_axis_tdata[26:24];
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected item %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got.rd !== want.rd || got.nmi !== want.nmi || got.v !== want.v ||
            got.fx !== want.fx) begin
          errors++;
          if (errors <= 10)
            $display("tb: mismatch rd %h/%h nmi %b/%b v %h/%h fx %0d/%0d (exp/got)",
                     want.rd, got.rd, want.nmi, got.nmi, want.v, got.v, want.fx, got.fx);
        end
      end
    end
  end

  initial begin
    int ph, w;
    errors = 0;
    hold_asked = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    src_idle = 12;
    dst_idle = 85;

    sh_mirror = 1'b1;
    sh_v = '0; sh_t = '0; sh_fx = '0; sh_toggle = 1'b0;
    sh_buf = '0; sh_ctrl = '0; sh_mask = '0; sh_oam_ptr = '0; sh_status = '0;
    foreach (oam_wr[i]) oam_wr[i] = 0;
    foreach (nt_wr[i]) nt_wr[i] = 0;
    foreach (pal_wr[i]) pal_wr[i] = 0;
    foreach (pat_wr[i]) pat_wr[i] = 0;
    sh_pal[0] = 8'h0F;
    pal_wr[0] = 1;

    dir_rows.push_back('{MODE_READ, REG_STATUS, 8'hFF, 1, '{8'h00, 1'b0, 15'h0, 3'd0}});
    dir_rows.push_back('{MODE_READ, REG_CTRL, 8'h00, 1, '{8'h00, 1'b0, 15'h0, 3'd0}});
    dir_rows.push_back('{MODE_WRITE, REG_MASK, 8'h18, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_CTRL, 8'h80, 0, '0});
    dir_rows.push_back('{MODE_VBL, 3'd0, 8'h00, 1, '{8'h00, 1'b1, 15'h0, 3'd0}});
    dir_rows.push_back('{MODE_READ, REG_STATUS, 8'h00, 1, '{8'h80, 1'b0, 15'h0, 3'd0}});
    dir_rows.push_back('{MODE_HIT, 3'd7, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_OVF, 3'd0, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_READ, REG_STATUS, 8'h00, 1, '{8'h60, 1'b0, 15'h0, 3'd0}});
    dir_rows.push_back('{MODE_CLR, 3'd0, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_SCROLL, 8'hFF, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_SCROLL, 8'hFF, 0, '0});
    // write name table behind the palette, then read palette entry zero
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'h2F, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_DATA, 8'hAA, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'hFF, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_READ, REG_DATA, 8'h00, 1, '{8'h0F, 1'b0, 15'h3F01, 3'd7}});
    dir_rows.push_back('{MODE_WRITE, REG_STATUS, 8'hFF, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'h23, 0, '0});
    dir_rows.push_back('{MODE_WRITE, REG_ADDR, 8'hBF, 0, '0});
    dir_rows.push_back('{MODE_CX, 3'd0, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_FY, 3'd0, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_COPYX, 3'd0, 8'h00, 0, '0});
    dir_rows.push_back('{MODE_COPYY, 3'd0, 8'h00, 0, '0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (ph = 0; ph < 3; ph++) begin
      if (ph > 0) wait_drained();
      set_mirror(ph == 1);
      src_idle = (ph == 0) ? 12 : (ph == 1) ? 85 : 0;
      dst_idle = (ph == 0) ? 85 : (ph == 1) ? 12 : 0;
      if (ph == 0) begin
        foreach (dir_rows[i])
          offer(dir_rows[i].mode, dir_rows[i].rg, dir_rows[i].wd,
                dir_rows[i].typed, dir_rows[i].res);
        offer(4'd15, 3'd7, 8'hFF);
      end
      random_run(530);
    end
    s_axis_tvalid <= 1'b0;

    w = 0;
    while (pending_res.size() != 0 && w < 200000) begin
      @(negedge clk);
      w++;
    end
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
